@@ rtl/core/bds_pkg.sv @@
`timescale 1ns / 1ps

package bds_pkg;

    localparam int BLOCK_COLS   = 4;
    localparam int BLOCK_ROWS   = 8;
    localparam int SUM_SHIFT    = 5;
    localparam int SUM_W        = 13;
    localparam int PIX_W        = 8;
    localparam int ACC_W        = 3 * SUM_W;
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 4096;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int IMG_W_W      = 11;
    localparam int IMG_H_W      = 13;
    localparam int BCOL_W       = 8;
    localparam int BROW_W       = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    // Per-pixel control that rides along with the request into the accumulator.
    typedef struct packed {
        logic              first;
        logic              emit;
        logic              row_end;
        logic              frame_end;
        logic [BCOL_W-1:0] block_col;
        logic [BROW_W-1:0] block_row;
    } bds_tag_t;

endpackage

@@ rtl/core/box_downsample_8x4.sv @@
`timescale 1ns / 1ps
// A pixel's accumulator entry is read as it enters s1; s1 writes the entry back and moves
// a finished block to the output register. It takes one pixel per cycle unless a finished
// block waits in s1 on a stalled output; back-to-back same-entry updates are forwarded.
// Output register stalls only when a result is pending and m_tready is low.
// Reset: synchronous, active low; clears counters and handshake state and loads
// image size 1024 x 4096 (clamped to MAX_*). The accumulator memory is not cleared.

module box_downsample_8x4 import bds_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // red_in, green_in, blue_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // red_out, green_out, blue_out, block_col,
                                             // block_row, zero fill
    output logic                  m_tlast,   // row_end
    output logic                  m_tuser,   // frame_end
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NUM_BCOLS = (MAX_WIDTH + BLOCK_COLS - 1) / BLOCK_COLS;
    localparam int AW        = (NUM_BCOLS > 1) ? $clog2(NUM_BCOLS) : 1;

    logic [AW-1:0]      pix_addr;
    bds_tag_t           pix_tag;
    bds_tag_t           out_tag;
    logic [3*PIX_W-1:0] out_pix;
    logic               accept;

    assign accept = s_tvalid && s_tready;

    bds_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_accept (accept),
        .pix_addr   (pix_addr),
        .pix_tag    (pix_tag)
    );

    bds_accum #(
        .DEPTH (NUM_BCOLS),
        .AW    (AW)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (s_tdata),
        .in_addr   (pix_addr),
        .in_tag    (pix_tag),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix),
        .out_tag   (out_tag)
    );

    assign m_tdata = {7'd0, out_tag.block_row, out_tag.block_col, out_pix};
    assign m_tlast = out_tag.row_end;
    assign m_tuser = out_tag.frame_end;

endmodule

@@ rtl/core/bds_ctrl.sv @@
`timescale 1ns / 1ps

module bds_ctrl import bds_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int AW         = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pix_accept,
    output logic [AW-1:0]         pix_addr,
    output bds_tag_t              pix_tag
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] w_last_reg, w_last_next;
    logic [RW-1:0] h_last_reg, h_last_next;
    logic [IMG_W_W-1:0] w_val;
    logic [IMG_H_W-1:0] h_val;
    logic cfg_wr;
    logic last_col, last_row;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign w_val     = cfg_data[IMG_W_W-1:0];
    assign h_val     = cfg_data[IMG_H_W-1:0];

    assign last_col = (col_reg == w_last_reg);
    assign last_row = (row_reg == h_last_reg);

    always_comb begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_wr) begin
            col_next = '0;
            row_next = '0;
            unique case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    // zero acts as one pixel, oversize as the maximum
                    if (w_val == '0) begin
                        w_last_next = '0;
                    end else if (int'(w_val) > MAX_WIDTH) begin
                        w_last_next = CW'(MAX_WIDTH - 1);
                    end else begin
                        w_last_next = CW'(int'(w_val) - 1);
                    end
                end
                REG_IMAGE_HEIGHT: begin
                    if (h_val == '0) begin
                        h_last_next = '0;
                    end else if (int'(h_val) > MAX_HEIGHT) begin
                        h_last_next = RW'(MAX_HEIGHT - 1);
                    end else begin
                        h_last_next = RW'(int'(h_val) - 1);
                    end
                end
                default: begin
                    col_next = col_reg;
                    row_next = row_reg;
                end
            endcase
        end else if (pix_accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            w_last_reg <= CW'(W_RST - 1);
            h_last_reg <= RW'(H_RST - 1);
        end else begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
        end
    end

    assign pix_addr = AW'(col_reg >> 2);

    always_comb begin
        pix_tag.first     = (row_reg[2:0] == '0) && (col_reg[1:0] == '0);
        pix_tag.emit      = ((col_reg[1:0] == 2'(BLOCK_COLS - 1)) || last_col) &&
                            ((row_reg[2:0] == 3'(BLOCK_ROWS - 1)) || last_row);
        pix_tag.row_end   = last_col;
        pix_tag.frame_end = last_col && last_row;
        pix_tag.block_col = BCOL_W'(col_reg >> 2);
        pix_tag.block_row = BROW_W'(row_reg >> 3);
    end

endmodule

@@ rtl/core/bds_accum.sv @@
`timescale 1ns / 1ps

module bds_accum import bds_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3*PIX_W-1:0]  in_pix,
    input  logic [AW-1:0]       in_addr,
    input  bds_tag_t            in_tag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3*PIX_W-1:0]  out_pix,
    output bds_tag_t            out_tag
);

    logic [ACC_W-1:0] mem [DEPTH];
    logic [ACC_W-1:0] rdata_reg;

    logic              s1_valid_reg, s1_valid_next;
    logic [AW-1:0]     s1_addr_reg;
    logic [3*PIX_W-1:0] s1_pix_reg;
    bds_tag_t          s1_tag_reg;
    logic              fwd_reg;
    logic [ACC_W-1:0]  wb_reg;

    logic              m_valid_reg, m_valid_next;
    logic [3*PIX_W-1:0] m_pix_reg;
    bds_tag_t          m_tag_reg;

    logic              accept, s1_done;
    logic [ACC_W-1:0]  base, sum;

    assign s1_done  = s1_valid_reg && (!s1_tag_reg.emit || !m_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_done;
    assign accept   = in_valid && in_ready;

    // entry written on the same edge as this request's read: take it from wb_reg
    assign base = fwd_reg ? wb_reg : rdata_reg;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (s1_tag_reg.first) begin
                sum[ch*SUM_W +: SUM_W] = SUM_W'(s1_pix_reg[ch*PIX_W +: PIX_W]);
            end else begin
                sum[ch*SUM_W +: SUM_W] = base[ch*SUM_W +: SUM_W] +
                                         SUM_W'(s1_pix_reg[ch*PIX_W +: PIX_W]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_done) begin
            mem[s1_addr_reg] <= sum;
        end
        if (accept) begin
            rdata_reg <= mem[in_addr];
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_done) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_done && s1_tag_reg.emit) begin
            m_valid_next = 1'b1;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (accept) begin
                fwd_reg <= s1_done && (s1_addr_reg == in_addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg <= in_addr;
            s1_pix_reg  <= in_pix;
            s1_tag_reg  <= in_tag;
        end
        if (s1_done) begin
            wb_reg <= sum;
        end
        if (s1_done && s1_tag_reg.emit) begin
            for (int ch = 0; ch < 3; ch++) begin
                m_pix_reg[ch*PIX_W +: PIX_W] <= sum[ch*SUM_W + SUM_SHIFT +: PIX_W];
            end
            m_tag_reg <= s1_tag_reg;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_pix   = m_pix_reg;
    assign out_tag   = m_tag_reg;

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_done) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("stalled accumulator request lost its entry");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (s1_valid_reg && s1_tag_reg.emit && m_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

    a_fwd_hazard: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s1_done && (s1_addr_reg == in_addr)) |=> fwd_reg)
        else $error("back-to-back update of one entry not forwarded");

    a_emit_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_done && s1_tag_reg.emit) |=> out_valid)
        else $error("finished block did not reach the output");

endmodule

@@ verif/tb_box_downsample_8x4.sv @@
`timescale 1ns / 1ps

module tb_box_downsample_8x4;
    import bds_pkg::*;

    localparam int IMG_MAX_W   = 1024;
    localparam int IMG_MAX_H   = 4096;
    localparam int NUM_BCOLS   = (IMG_MAX_W + BLOCK_COLS - 1) / BLOCK_COLS;
    localparam int RES_BITS    = 3 * PIX_W + BCOL_W + BROW_W;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_LIMIT = 2000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RAND_ITEMS  = 320;
    localparam int TALL_ITEMS  = 256;

    // indexes outside the register map; the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic              frame_end;
        logic              row_end;
        logic [BROW_W-1:0] block_row;
        logic [BCOL_W-1:0] block_col;
        logic [PIX_W-1:0]  blue;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  red;
    } block_avg_t;

    typedef enum {
        FILL_RANDOM,
        FILL_ALL_MAX,
        FILL_ALL_ZERO,
        FILL_EXTREMES
    } fill_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // pixel requests not yet accepted, and block averages not yet seen
    pixel_t     pixel_q[$];
    block_avg_t expected_blocks[$];

    // predictor state
    logic [IMG_W_W-1:0] cfg_width = IMG_W_W'(WIDTH_RESET);
    logic [IMG_H_W-1:0] cfg_height = IMG_H_W'(HEIGHT_RESET);
    int unsigned        pix_col = 0;
    int unsigned        pix_row = 0;
    logic [SUM_W-1:0]   sum_red[NUM_BCOLS];
    logic [SUM_W-1:0]   sum_green[NUM_BCOLS];
    logic [SUM_W-1:0]   sum_blue[NUM_BCOLS];

    int          err_cnt = 0;
    int unsigned idle_pct = 0;
    logic        s_fired = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    bit          hold_arm = 1'b0;
    bit          hold_taken = 1'b0;
    int unsigned rand_items = 0;

    box_downsample_8x4 #(
        .MAX_WIDTH (IMG_MAX_W),
        .MAX_HEIGHT(IMG_MAX_H)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic bit accumulate_pixel(input pixel_t px, output block_avg_t avg);
        int unsigned w, h, bc, br;
        bit          corner, last_col, last_row, done;
        w = eff_dim(cfg_width, IMG_MAX_W);
        h = eff_dim(cfg_height, IMG_MAX_H);
        bc = pix_col / BLOCK_COLS;
        br = pix_row / BLOCK_ROWS;
        corner = (pix_row % BLOCK_ROWS == 0) && (pix_col % BLOCK_COLS == 0);
        if (corner) begin
            sum_red[bc]   = px.red;
            sum_green[bc] = px.green;
            sum_blue[bc]  = px.blue;
        end else begin
            sum_red[bc]   = sum_red[bc] + px.red;
            sum_green[bc] = sum_green[bc] + px.green;
            sum_blue[bc]  = sum_blue[bc] + px.blue;
        end
        last_col = (pix_col == w - 1);
        last_row = (pix_row == h - 1);
        done = ((pix_col % BLOCK_COLS == BLOCK_COLS - 1) || last_col) &&
               ((pix_row % BLOCK_ROWS == BLOCK_ROWS - 1) || last_row);
        avg.red       = PIX_W'(sum_red[bc] >> SUM_SHIFT);
        avg.green     = PIX_W'(sum_green[bc] >> SUM_SHIFT);
        avg.blue      = PIX_W'(sum_blue[bc] >> SUM_SHIFT);
        avg.block_col = BCOL_W'(bc);
        avg.block_row = BROW_W'(br);
        avg.row_end   = last_col;
        avg.frame_end = last_col && last_row;
        if (last_col) begin
            pix_col = 0;
            pix_row = last_row ? 0 : pix_row + 1;
        end else begin
            pix_col = pix_col + 1;
        end
        return done;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_block();
        block_avg_t got, want;
        got = {m_tuser, m_tlast, m_tdata[RES_BITS-1:0]};
        if (expected_blocks.size() == 0) begin
            report_error("block result with nothing pending");
            return;
        end
        want = expected_blocks.pop_front();
        check_field("red_out", 16'(got.red), 16'(want.red));
        check_field("green_out", 16'(got.green), 16'(want.green));
        check_field("blue_out", 16'(got.blue), 16'(want.blue));
        check_field("block_col", 16'(got.block_col), 16'(want.block_col));
        check_field("block_row", 16'(got.block_row), 16'(want.block_row));
        check_field("row_end", 16'(got.row_end), 16'(want.row_end));
        check_field("frame_end", 16'(got.frame_end), 16'(want.frame_end));
    endtask

    // monitor: results checked before the same edge's pixel is predicted
    always @(posedge aclk) begin : monitor
        pixel_t     px;
        block_avg_t avg;
        s_fired <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_block();
            if (s_tvalid && s_tready) begin
                px = pixel_q.pop_front();
                if (accumulate_pixel(px, avg))
                    expected_blocks.push_back(avg);
            end
        end
    end

    // pixel driver; a request stays up until taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fired) begin
            s_tvalid <= 1'b1;
        end else if (tx_gap != 0) begin
            tx_gap   <= tx_gap - 1;
            s_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0 && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            tx_gap   <= $urandom_range(7);
            s_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= pixel_q[0];
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result side backpressure, including one long hold on request
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_arm != hold_taken) begin
            hold_taken <= hold_arm;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            rx_gap   <= $urandom_range(7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
            if (idx == REG_IMAGE_WIDTH)
                cfg_width = val[IMG_W_W-1:0];
            else
                cfg_height = val[IMG_H_W-1:0];
            pix_col = 0;
            pix_row = 0;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_pixels(input int unsigned n, input fill_t fill);
        pixel_t px;
        for (int unsigned i = 0; i < n; i++) begin
            case (fill)
                FILL_ALL_MAX:  px = '1;
                FILL_ALL_ZERO: px = '0;
                FILL_EXTREMES: begin
                    px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
                    px.green = $urandom_range(1) ? 8'hFF : 8'h00;
                    px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
                end
                default:       px = pixel_t'($urandom);
            endcase
            pixel_q.push_back(px);
        end
    endtask

    // block is idle once every pixel is taken, every block seen, plus its latency
    task automatic wait_idle();
        int unsigned spins;
        spins = 0;
        while (pixel_q.size() != 0)
            @(posedge aclk);
        while (expected_blocks.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge aclk);
            spins++;
        end
        if (expected_blocks.size() != 0) begin
            report_error($sformatf("%0d block results never arrived", expected_blocks.size()));
            expected_blocks.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random_phase();
        logic [CFG_DATA_W-1:0] wv, hv;
        int unsigned           frame, n;
        fill_t                 fill;
        case ($urandom_range(15))
            0:       wv = '0;
            1:       wv = CFG_DATA_W'($urandom_range(2047, IMG_MAX_W + 1));
            2:       wv = CFG_DATA_W'(IMG_MAX_W);
            default: wv = CFG_DATA_W'($urandom_range(24, 1));
        endcase
        if ($urandom_range(3) == 0)
            wv[CFG_DATA_W-1:IMG_W_W] = 2'($urandom_range(3));
        case ($urandom_range(15))
            0:       hv = '0;
            1:       hv = CFG_DATA_W'($urandom_range(8191, IMG_MAX_H + 1));
            default: hv = CFG_DATA_W'($urandom_range(20, 1));
        endcase
        case ($urandom_range(3))
            0: write_reg(REG_IMAGE_WIDTH, wv);
            1: write_reg(REG_IMAGE_HEIGHT, hv);
            2: begin
                write_reg(REG_IMAGE_WIDTH, wv);
                write_reg(REG_IMAGE_HEIGHT, hv);
            end
            default: begin
                write_reg(REG_IMAGE_HEIGHT, hv);
                write_reg(REG_IMAGE_WIDTH, wv);
            end
        endcase
        if ($urandom_range(5) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
        frame = eff_dim(cfg_width, IMG_MAX_W) * eff_dim(cfg_height, IMG_MAX_H);
        // mostly whole frames; the rest stops mid-frame and restarts on the next write
        if (frame <= 150 && $urandom_range(3) != 0)
            n = frame * $urandom_range(3, 1);
        else
            n = $urandom_range(160, 10);
        case ($urandom_range(7))
            0:       fill = FILL_ALL_MAX;
            1:       fill = FILL_ALL_ZERO;
            2:       fill = FILL_EXTREMES;
            default: fill = FILL_RANDOM;
        endcase
        if (rand_items >= RAND_ITEMS - 250) begin
            idle_pct = 0;
        end else begin
            case ($urandom_range(3))
                0:       idle_pct = 0;
                1:       idle_pct = 5;
                2:       idle_pct = 20;
                default: idle_pct = 50;
            endcase
        end
        push_pixels(n, fill);
        rand_items += n;
        wait_idle();
    endtask

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_box_downsample_8x4 NOT OK");
        $finish;
    end

    initial begin : stimulus
        pixel_t px;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset size is 1024 x 4096: a few pixels, nothing may come out
        idle_pct = 20;
        push_pixels(6, FILL_EXTREMES);
        wait_idle();

        // zero sizes act as 1 x 1: every pixel closes a frame
        write_reg(REG_IMAGE_WIDTH, '0);
        write_reg(REG_IMAGE_HEIGHT, '0);
        push_pixels(1, FILL_ALL_MAX);
        push_pixels(1, FILL_ALL_ZERO);
        px = {8'hAA, 8'h55, 8'hAA};
        pixel_q.push_back(px);
        px = {8'h55, 8'hAA, 8'h55};
        pixel_q.push_back(px);
        wait_idle();

        // writes to unmapped indexes must not restart the frame
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        push_pixels(3, FILL_RANDOM);
        wait_idle();
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, 13'd1);
        push_pixels(3, FILL_RANDOM);
        wait_idle();

        // width bits above the register are dropped: 5 pixels wide
        write_reg(REG_IMAGE_WIDTH, 13'h1805);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        push_pixels(5, FILL_ALL_MAX);
        wait_idle();

        // oversize width clamps to the maximum: one row of 256 blocks
        write_reg(REG_IMAGE_WIDTH, 13'h07FF);
        push_pixels(IMG_MAX_W, FILL_RANDOM);
        wait_idle();

        // oversize height acts as the maximum: a tall single column, no frame end yet
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        idle_pct = 5;
        push_pixels(TALL_ITEMS, FILL_RANDOM);
        wait_idle();

        // long receiver hold with a result every second pixel, then a full pause mid-frame
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        idle_pct = 0;
        hold_arm = ~hold_arm;
        push_pixels(60, FILL_RANDOM);
        wait_idle();
        idle_pct = 20;
        push_pixels(21, FILL_RANDOM);
        wait_idle();

        while (rand_items < RAND_ITEMS)
            run_random_phase();

        repeat (8) @(posedge aclk);
        if (err_cnt == 0)
            $display("tb_box_downsample_8x4 OK");
        else
            $display("tb_box_downsample_8x4 NOT OK");
        $finish;
    end

endmodule

@@ box_downsample_8x4.f @@
rtl/core/bds_pkg.sv
rtl/core/bds_ctrl.sv
rtl/core/bds_accum.sv
rtl/core/box_downsample_8x4.sv
verif/tb_box_downsample_8x4.sv
